>>> hw/rtl/prm_pkg.sv
`default_nettype none
package prm_pkg;

   localparam int CHANNELS   = 4;
   localparam int CH_W       = $clog2(CHANNELS);
   localparam int SAMPLE_W   = 24;
   localparam int SUM_W      = 62;
   localparam int DIV_STEPS  = SUM_W;
   localparam int SQRT_STEPS = SUM_W / 2;
   localparam int ROOT_W     = SQRT_STEPS;

   localparam logic [15:0] SPT_RESET = 16'd1024;

   // register indexes on the csr port
   localparam logic REG_SAMPLES = 1'b0;
   localparam logic REG_LAG     = 1'b1;

   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] peak;
      logic [SAMPLE_W-1:0] rms;
   } lane_out_type;

endpackage
`default_nettype wire

>>> hw/rtl/prm_lane.sv
`default_nettype none
module prm_lane
   import prm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                acc_en,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic                start,
   input  wire logic [15:0]         win_len,
   input  wire logic [15:0]         lag,
   output      lane_out_type        status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SQRT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] held_ff, held_in;
   logic [SUM_W-1:0]    work_ff, work_in;
   logic [15:0]         drem_ff, drem_in;
   logic [15:0]         div_ff, div_in;
   logic [32:0]         srem_ff, srem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;

   logic [SAMPLE_W:0]     mag_wide;
   logic [SAMPLE_W-1:0]   mag;
   logic [2*SAMPLE_W-1:0] square;
   logic [SAMPLE_W-1:0]   diff;
   logic [39:0]           decay;
   logic [16:0]           dtrial;
   logic                  dge;
   logic [34:0]           sr;
   logic [34:0]           strial;
   logic                  sge;

   always_comb begin
      mag_wide = sample[SAMPLE_W-1] ? (25'h1000000 - {1'b0, sample}) : {1'b0, sample};
      mag      = mag_wide[SAMPLE_W-1:0];
      square   = mag * mag;
      diff     = held_ff - peak_ff;
      decay    = lag * diff;
      dtrial   = {drem_ff, work_ff[SUM_W-1]};
      dge      = dtrial >= {1'b0, div_ff};
      sr       = {srem_ff, work_ff[SUM_W-1 -: 2]};
      strial   = {2'b00, root_ff, 2'b01};
      sge      = sr >= strial;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      peak_in  = peak_ff;
      sum_in   = sum_ff;
      held_in  = held_ff;
      work_in  = work_ff;
      drem_in  = drem_ff;
      div_in   = div_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      if (acc_en) begin
         if (mag > peak_ff) begin
            peak_in = mag;
         end
         sum_in = sum_ff + SUM_W'(square);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // snapshot the window and clear the accumulators
               work_in  = sum_ff;
               drem_in  = '0;
               div_in   = win_len;
               peak_in  = '0;
               sum_in   = '0;
               held_in  = (peak_ff >= held_ff) ? peak_ff : peak_ff + decay[39:16];
               cnt_in   = 6'(DIV_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            drem_in = dge ? 16'(dtrial - {1'b0, div_ff}) : dtrial[15:0];
            work_in = {work_ff[SUM_W-2:0], dge};
            if (cnt_ff == '0) begin
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = 6'(SQRT_STEPS - 1);
               state_in = ST_SQRT;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         ST_SQRT: begin
            // one result bit per cycle, two radicand bits consumed
            srem_in = sge ? 33'(sr - strial) : sr[32:0];
            root_in = {root_ff[ROOT_W-2:0], sge};
            work_in = {work_ff[SUM_W-3:0], 2'b00};
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         peak_ff  <= '0;
         sum_ff   <= '0;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         peak_ff  <= peak_in;
         sum_ff   <= sum_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      drem_ff <= drem_in;
      div_ff  <= div_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

   always_comb begin
      status.done = state_ff == ST_DONE;
      status.peak = held_ff;
      status.rms  = root_ff[SAMPLE_W-1:0];
   end

endmodule
`default_nettype wire

>>> hw/rtl/prm_report.sv
`default_nettype none
module prm_report
   import prm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire lane_out_type        lanes [CHANNELS],
   input  wire logic                rsp_stall,
   output      logic                rsp_valid,
   output      logic [1:0]          rsp_channel,
   output      logic [SAMPLE_W-1:0] rsp_peak_level,
   output      logic [SAMPLE_W-1:0] rsp_rms_level,
   output      logic                rsp_last,
   output      logic                finish
);

   logic                valid_ff, valid_in;
   logic [CH_W-1:0]     ch_ff, ch_in;
   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [SAMPLE_W-1:0] rms_ff, rms_in;
   logic                last_ff, last_in;
   logic                take;
   logic [CH_W-1:0]     sel;

   assign take = valid_ff && !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      ch_in    = ch_ff;
      sel      = ch_ff + 1'b1;
      if (start) begin
         valid_in = 1'b1;
         sel      = '0;
         ch_in    = '0;
      end else if (take) begin
         if (last_ff) begin
            valid_in = 1'b0;
         end else begin
            ch_in = sel;
         end
      end
      peak_in = lanes[sel].peak;
      rms_in  = lanes[sel].rms;
      last_in = sel == CH_W'(CHANNELS - 1);
      if (!start && !(take && !last_ff)) begin
         peak_in = peak_ff;
         rms_in  = rms_ff;
         last_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ch_ff    <= '0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         ch_ff    <= ch_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      peak_ff <= peak_in;
      rms_ff  <= rms_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_channel    = 2'(ch_ff);
   assign rsp_peak_level = peak_ff;
   assign rsp_rms_level  = rms_ff;
   assign rsp_last       = last_ff;
   assign finish         = take && last_ff;

endmodule
`default_nettype wire

>>> hw/rtl/multichannel_peak_rms_meter.sv
`default_nettype none
// a request that does not close a window is absorbed with no response
// a closing request: close_ff, lane DIV, SQRT, DONE, report register; then one response per channel
// throughput: 1 request per cycle inside a window; the closing one holds req_stall high
// until the last channel's response is taken (62-step divider, then 31-step square root)
// reset: synchronous, clears all accumulators and held levels, window length back to 1024
module multichannel_peak_rms_meter
   import prm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample_ch0,
   input  wire logic [SAMPLE_W-1:0] req_sample_ch1,
   input  wire logic [SAMPLE_W-1:0] req_sample_ch2,
   input  wire logic [SAMPLE_W-1:0] req_sample_ch3,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [1:0]          rsp_channel,
   output      logic [SAMPLE_W-1:0] rsp_peak_level,
   output      logic [SAMPLE_W-1:0] rsp_rms_level,
   output      logic                rsp_last,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output      logic [31:0]         prdata,
   output      logic                pready
);

   logic [15:0] spt_ff, spt_in;
   logic [15:0] lag_ff, lag_in;
   logic [15:0] left_ff, left_in;
   logic        busy_ff, busy_in;
   logic        close_ff;
   logic [15:0] win_len;
   logic        accept;
   logic        close;
   logic        finish;
   logic        wr;

   logic [SAMPLE_W-1:0] samples [CHANNELS];
   lane_out_type        lanes   [CHANNELS];

   assign samples[0] = req_sample_ch0;
   assign samples[1] = req_sample_ch1;
   assign samples[2] = req_sample_ch2;
   assign samples[3] = req_sample_ch3;

   assign pready    = 1'b1;
   assign wr        = psel && penable && pwrite;
   assign win_len   = (spt_ff == '0) ? 16'd1 : spt_ff;
   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign close     = accept && (left_ff == 16'd1);

   always_comb begin
      unique case (paddr[2])
         REG_SAMPLES: prdata = {16'd0, spt_ff};
         REG_LAG:     prdata = {16'd0, lag_ff};
         default:     prdata = '0;
      endcase
   end

   always_comb begin
      spt_in  = spt_ff;
      lag_in  = lag_ff;
      left_in = left_ff;
      busy_in = busy_ff;
      if (wr) begin
         unique case (paddr[2])
            REG_SAMPLES: spt_in = pwdata[15:0];
            REG_LAG:     lag_in = pwdata[15:0];
            default:     spt_in = spt_ff;
         endcase
      end
      if (accept) begin
         left_in = close ? win_len : left_ff - 16'd1;
      end
      priority if (close) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff   <= SPT_RESET;
         lag_ff   <= '0;
         left_ff  <= SPT_RESET;
         busy_ff  <= 1'b0;
         close_ff <= 1'b0;
      end else begin
         spt_ff   <= spt_in;
         lag_ff   <= lag_in;
         left_ff  <= left_in;
         busy_ff  <= busy_in;
         close_ff <= close;
      end
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      prm_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .acc_en  (accept),
         .sample  (samples[c]),
         .start   (close_ff),
         .win_len (win_len),
         .lag     (lag_ff),
         .status  (lanes[c])
      );
   end

   prm_report u_report (
      .clock          (clock),
      .reset          (reset),
      .start          (lanes[0].done),
      .lanes          (lanes),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_channel    (rsp_channel),
      .rsp_peak_level (rsp_peak_level),
      .rsp_rms_level  (rsp_rms_level),
      .rsp_last       (rsp_last),
      .finish         (finish)
   );

   // no request may enter while responses are pending
   a_stall_while_reporting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while responses pending");

   // lanes finish together and only inside a window close
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      lanes[0].done |-> (busy_ff && lanes[CHANNELS-1].done))
      else $error("lane finished out of step");

   // a taken non-final response is followed by another valid response
   a_next_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("response sequence broken");

endmodule
`default_nettype wire

>>> bench/testbench.sv
`default_nettype none
module testbench
   import prm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 600;

   typedef struct packed {
      logic [SAMPLE_W-1:0] s0;
      logic [SAMPLE_W-1:0] s1;
      logic [SAMPLE_W-1:0] s2;
      logic [SAMPLE_W-1:0] s3;
   } frame_type;

   typedef struct packed {
      logic [1:0]          channel;
      logic [SAMPLE_W-1:0] peak;
      logic [SAMPLE_W-1:0] rms;
      logic                last;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [SAMPLE_W-1:0] req_sample_ch0 = '0, req_sample_ch1 = '0;
   logic [SAMPLE_W-1:0] req_sample_ch2 = '0, req_sample_ch3 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_channel;
   logic [SAMPLE_W-1:0] rsp_peak_level, rsp_rms_level;
   logic rsp_last;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   multichannel_peak_rms_meter DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [15:0] window_setting, decay_coef, frames_to_go;
   logic [SAMPLE_W-1:0] peak_acc [CHANNELS];
   logic [SUM_W-1:0]    energy_acc [CHANNELS];
   logic [SAMPLE_W-1:0] held_peak [CHANNELS];

   frame_type  pending_frames[$];
   report_type expected_reports[$];
   int errors = 0;
   int frames_sent = 0, reports_seen = 0, windows_closed = 0;
   int idle_pct = 27;
   bit hold_off = 1'b0;
   bit hold_done = 1'b0;
   int hold_cnt = 0;
   int idle_cycles = 0;

   function automatic logic [24:0] mag(logic [SAMPLE_W-1:0] s);
      logic [24:0] v;
      v = {s[SAMPLE_W-1], s};
      return v[24] ? -v : v;
   endfunction

   function automatic logic [31:0] root_floor(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r[31:0];
   endfunction

   task automatic meter_frame(frame_type f);
      logic [24:0] m [CHANNELS];
      logic [15:0] len;
      logic [63:0] held, pk;
      report_type r;
      m[0] = mag(f.s0); m[1] = mag(f.s1); m[2] = mag(f.s2); m[3] = mag(f.s3);
      for (int c = 0; c < CHANNELS; c++) begin
         if (m[c] > peak_acc[c]) peak_acc[c] = m[c][SAMPLE_W-1:0];
         energy_acc[c] += m[c] * m[c];
      end
      frames_to_go = frames_to_go - 16'd1;
      if (frames_to_go != 0) return;
      len = (window_setting == 0) ? 16'd1 : window_setting;
      frames_to_go = len;
      windows_closed++;
      for (int c = 0; c < CHANNELS; c++) begin
         pk = peak_acc[c];
         held = held_peak[c];
         if (pk >= held) held = pk;
         else held = pk + ((decay_coef * (held - pk)) >> 16);
         held_peak[c] = held[SAMPLE_W-1:0];
         r.channel = c[1:0];
         r.peak = held[SAMPLE_W-1:0];
         r.rms = 24'(root_floor(64'(energy_acc[c]) / len));
         r.last = (c == CHANNELS - 1);
         expected_reports.push_back(r);
         peak_acc[c] = '0;
         energy_acc[c] = '0;
      end
   endtask

   task automatic csr_write(logic reg_idx, logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= {reg_idx, 2'b00}; pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (reg_idx == REG_SAMPLES) window_setting = value;
      else decay_coef = value;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (pending_frames.size() > 0 && $urandom_range(99) >= idle_pct) begin
            frame_type f;
            f = pending_frames.pop_front();
            meter_frame(f);
            frames_sent++;
            req_valid <= 1'b1;
            req_sample_ch0 <= f.s0; req_sample_ch1 <= f.s1;
            req_sample_ch2 <= f.s2; req_sample_ch3 <= f.s3;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cnt  <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
               $error("unexpected report for channel %0d", rsp_channel);
               errors++;
            end else begin
               report_type e;
               e = expected_reports.pop_front();
               if (rsp_channel !== e.channel) begin
                  $error("channel: expected %0d got %0d", e.channel, rsp_channel); errors++;
               end
               if (rsp_peak_level !== e.peak) begin
                  $error("peak_level: expected %0d got %0d", e.peak, rsp_peak_level); errors++;
               end
               if (rsp_rms_level !== e.rms) begin
                  $error("rms_level: expected %0d got %0d", e.rms, rsp_rms_level); errors++;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0d got %0d", e.last, rsp_last); errors++;
               end
            end
         end
         if (hold_cnt != 0) begin
            rsp_stall <= 1'b1;
            hold_cnt  <= hold_cnt - 1;
         end else if (hold_off && !hold_done) begin
            // one long hold-off, counted here
            rsp_stall <= 1'b1;
            hold_cnt  <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_pct);
         end
      end
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL multichannel_peak_rms_meter");
         $finish;
      end
   end

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(5))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'(-$urandom_range(16) );
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic queue_frames(int n);
      frame_type f;
      repeat (n) begin
         f.s0 = rand_sample(); f.s1 = rand_sample();
         f.s2 = rand_sample(); f.s3 = rand_sample();
         pending_frames.push_back(f);
      end
   endtask

   task automatic drain();
      while (pending_frames.size() > 0 || expected_reports.size() > 0 || req_valid)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   initial begin
      window_setting = SPT_RESET;
      decay_coef = '0;
      frames_to_go = SPT_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
         peak_acc[c] = '0; energy_acc[c] = '0; held_peak[c] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: short windows of extremes, zero window length treated as one
      csr_write(REG_SAMPLES, 16'd0);
      csr_write(REG_LAG, 16'd65535);
      // first window still runs its reset length of 1024 frames
      pending_frames.push_back('{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF});
      repeat (1022) pending_frames.push_back('{24'h0, 24'h0, 24'h0, 24'h1});
      pending_frames.push_back('{24'h7FFFFF, 24'h800000, 24'h000001, 24'h0});
      pending_frames.push_back('{24'h000010, 24'h000020, 24'h000000, 24'h800000});
      pending_frames.push_back('{24'h0, 24'h0, 24'h0, 24'h0});
      pending_frames.push_back('{24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h0});
      drain();

      // window change mid-window takes effect at the next reload
      csr_write(REG_SAMPLES, 16'd3);
      csr_write(REG_LAG, 16'd32768);
      queue_frames(8);
      drain();
      csr_write(REG_SAMPLES, 16'd5);
      drain();

      csr_write(REG_LAG, 16'd0);
      queue_frames(20);
      drain();

      // long receiver hold-off while frames keep coming
      csr_write(REG_SAMPLES, 16'd1);
      csr_write(REG_LAG, 16'd60000);
      hold_off = 1'b1;
      queue_frames(30);
      drain();
      hold_off = 1'b0;

      // random phases
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_SAMPLES, 16'($urandom_range(1, 8)));
         csr_write(REG_LAG, (ph == 3) ? 16'hFFFF : 16'($urandom()));
         idle_pct = (ph == 5) ? 0 : 27;
         queue_frames(42);
         drain();
      end
      idle_pct = 27;

      $display("covered %0d frames, %0d windows, %0d reports",
               frames_sent, windows_closed, reports_seen);
      if (errors == 0 && expected_reports.size() == 0)
         $display("PASS multichannel_peak_rms_meter");
      else
         $display("FAIL multichannel_peak_rms_meter");
      $finish;
   end
endmodule
`default_nettype wire
